@@ hdl/sec2utc_pkg.sv @@
package sec2utc_pkg;

	// Calendar constants.
	localparam longint unsigned SecPerDay    = 86400;
	localparam longint unsigned SecPerHour   = 3600;
	localparam longint unsigned SecPerMin    = 60;
	localparam longint unsigned DaysPerWeek  = 7;
	localparam longint unsigned DaysPerEra   = 146097;
	localparam longint unsigned DaysPerCent  = 36524;
	localparam longint unsigned DaysPer4Yr   = 1460;
	localparam longint unsigned DaysPerYear  = 365;
	localparam longint unsigned DaysToMar1   = 719468;
	localparam longint unsigned YearsPerEra  = 400;
	localparam longint unsigned YearsPerCent = 100;
	localparam longint unsigned YearBase     = 1900;

	// The day split divides by 128 with a shift, then by the odd factor 675.
	localparam int unsigned     DayShift = 7;
	localparam longint unsigned DayDiv   = SecPerDay >> DayShift;

	// Biases that keep every quotient input non-negative.
	localparam longint unsigned DayBias = ((64'd1 << 40) + DayDiv - 1) / DayDiv;
	localparam longint unsigned EraBias = ((64'd1 << 31) + DaysPerEra - 1) / DaysPerEra;
	localparam longint unsigned ZBias   = DaysToMar1 + EraBias * DaysPerEra - DayBias;
	// 1970-01-01 was a Thursday; fold the day bias into the weekday offset.
	localparam longint unsigned WdayAdj = (4 + DaysPerWeek - DayBias % DaysPerWeek) % DaysPerWeek;

	// Number of register stages from the input beat to the output register.
	localparam int unsigned NumStages = 17;

	// First day of each month in a year that starts on March 1.
	localparam logic [8:0] MarchStart [12] = '{
		9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
		9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
	};

	// First day of each month in a year that starts on January 1 (common year).
	localparam logic [8:0] MonthStart [12] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	// Register enables of one constant divider.
	typedef struct packed {
		logic mul;
		logic fix;
	} cdiv_en_t;

	// Output beat layout, second in the lowest bits.
	typedef struct packed {
		logic [1:0]         pad;
		logic [8:0]         day_of_year;
		logic [2:0]         weekday;
		logic signed [23:0] year_offset;
		logic [3:0]         month_index;
		logic [4:0]         day_of_month;
		logic [4:0]         hour;
		logic [5:0]         minute;
		logic [5:0]         second;
	} result_t;

endpackage

@@ hdl/sec2utc_cdiv.sv @@
// Two-stage division of an unsigned value by a constant.
// The first stage multiplies by floor(2^W / D), which gives the quotient or one
// less; the second stage forms the remainder and corrects by one step.
module sec2utc_cdiv import sec2utc_pkg::*; #(
	parameter int unsigned     W  = 32,
	parameter longint unsigned D  = 7,
	parameter int unsigned     QW = 8,
	parameter int unsigned     RW = 3
) (
	input  logic          clk,
	input  cdiv_en_t      en,
	input  logic [W-1:0]  y,
	output logic [QW-1:0] q,
	output logic [RW-1:0] r
);

	localparam longint unsigned M  = (64'd1 << W) / D;
	localparam int unsigned     MW = $clog2(M + 1);

	logic [W+MW-1:0] prod;
	logic [MW-1:0]   qe_s1;
	logic [W-1:0]    y_s1;
	logic [W-1:0]    rfull;
	logic            over;
	logic [MW-1:0]   q_s2;
	logic [W-1:0]    r_s2;

	// Reciprocal product; its upper bits are the quotient estimate.
	assign prod = (W+MW)'(y) * (W+MW)'(M);

	// Remainder of the estimate, which is below twice the divisor.
	assign rfull = y_s1 - W'(qe_s1 * D);
	assign over  = rfull >= W'(D);

	always_ff @(posedge clk) begin
		if (en.mul) begin
			qe_s1 <= prod[W+MW-1:W];
			y_s1  <= y;
		end
		if (en.fix) begin
			q_s2 <= over ? qe_s1 + 1'b1 : qe_s1;
			r_s2 <= over ? rfull - W'(D) : rfull;
		end
	end

	assign q = q_s2[QW-1:0];
	assign r = r_s2[RW-1:0];

endmodule

@@ hdl/unix_seconds_to_utc_date.sv @@
// Converts a signed count of seconds since 1970-01-01 00:00:00 UTC into the
// broken-down UTC date and time of the proleptic Gregorian calendar.
// Input channel: s_axis_*, one 48-bit two's complement time per beat.
// Output channel: m_axis_*, one 64-bit result per input beat, in input order.
// Throughput: one beat per cycle, sustained, as long as m_axis_tready is high.
// Depth: 17 register stages, from the input register to the output register.
// The stage count is set by the chain of constant dividers: seconds to days
// (two 21-bit digit steps by 675 after a shift by 128), days to 400-year eras,
// then four-year cycles, years of the era and the month lookup, each divider
// taking two stages.
// Each stage holds its own valid bit and moves forward whenever the stage after
// it is empty or moving, so bubbles close up while the receiver stalls, and the
// input is still taken until every stage is full. A stalled result holds
// steady on m_axis_tdata. Nothing is lost or repeated over a stall.
// Reset clears all valid bits at once; the block accepts beats as soon as
// arst_n is released. There is no configuration.
module unix_seconds_to_utc_date import sec2utc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // [47:0] epoch_seconds
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [5:0] second, [11:6] minute, [16:12] hour, [21:17] day_of_month,
	// [25:22] month_index, [49:26] year_offset, [52:50] weekday,
	// [61:53] day_of_year, [63:62] zero
	output logic [63:0] m_axis_tdata
);

	typedef struct packed {
		logic signed [23:0] era400;
		logic [2:0]         wday;
		logic [4:0]         hour;
		logic [5:0]         minute;
		logic [5:0]         second;
	} side_t;

	logic [NumStages:1] vld_q;
	logic [NumStages:1] adv;

	// Stage advance: a stage loads when it is empty or the next one loads.
	always_comb begin
		adv[NumStages] = !vld_q[NumStages] || m_axis_tready;
		for (int k = NumStages - 1; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= s_axis_tvalid;
			end
			for (int k = 2; k <= NumStages; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign s_axis_tready = adv[1];
	assign m_axis_tvalid = vld_q[NumStages];

	// Divider enables, one pair per divider.
	cdiv_en_t en_hi, en_lo, en_era, en_wk, en_hr, en_c4, en_min, en_yr;
	assign en_hi  = '{mul: adv[2],  fix: adv[3]};
	assign en_lo  = '{mul: adv[4],  fix: adv[5]};
	assign en_era = '{mul: adv[7],  fix: adv[8]};
	assign en_wk  = '{mul: adv[7],  fix: adv[8]};
	assign en_hr  = '{mul: adv[7],  fix: adv[8]};
	assign en_c4  = '{mul: adv[9],  fix: adv[10]};
	assign en_min = '{mul: adv[9],  fix: adv[10]};
	assign en_yr  = '{mul: adv[12], fix: adv[13]};

	// Stage 1: floor division by 128 and a bias that makes the value positive.
	logic signed [40:0] q128;
	logic [41:0]        x_s1;
	logic [6:0]         low7_s1;

	assign q128 = s_axis_tdata[47:DayShift];

	// Stages 2..5: two digit steps of the division by 675.
	logic [11:0] qh;
	logic [9:0]  rh;
	logic [20:0] qlo;
	logic [9:0]  rlo;
	logic [20:0] xl_s2, xl_s3;
	logic [6:0]  low7_s2, low7_s3, low7_s4, low7_s5;
	logic [11:0] qh_s4, qh_s5;

	sec2utc_cdiv #(.W(21), .D(DayDiv), .QW(12), .RW(10)) u_div_hi (
		.clk (clk),
		.en  (en_hi),
		.y   (x_s1[41:21]),
		.q   (qh),
		.r   (rh)
	);

	sec2utc_cdiv #(.W(31), .D(DayDiv), .QW(21), .RW(10)) u_div_lo (
		.clk (clk),
		.en  (en_lo),
		.y   ({rh, xl_s3}),
		.q   (qlo),
		.r   (rlo)
	);

	// Stage 6: biased day count, shifted day count and seconds of the day.
	logic [31:0] qa;
	logic [31:0] qa_s6;
	logic [31:0] zu_s6;
	logic [16:0] rem_s6;

	assign qa = 32'({qh_s5, qlo});

	// Stages 7..8: eras, weekday and hour.
	logic [14:0] era_q;
	logic [17:0] doe;
	logic [2:0]  r7;
	logic [4:0]  hour;
	logic [11:0] sec_hr;

	sec2utc_cdiv #(.W(32), .D(DaysPerEra), .QW(15), .RW(18)) u_div_era (
		.clk (clk),
		.en  (en_era),
		.y   (zu_s6),
		.q   (era_q),
		.r   (doe)
	);

	sec2utc_cdiv #(.W(32), .D(DaysPerWeek), .QW(1), .RW(3)) u_div_wk (
		.clk (clk),
		.en  (en_wk),
		.y   (qa_s6),
		.q   (),
		.r   (r7)
	);

	sec2utc_cdiv #(.W(17), .D(SecPerHour), .QW(5), .RW(12)) u_div_hr (
		.clk (clk),
		.en  (en_hr),
		.y   (rem_s6),
		.q   (hour),
		.r   (sec_hr)
	);

	// Stage 9: weekday wrap, era year base and the century correction.
	logic signed [15:0] era_sgn;
	logic signed [23:0] era400;
	logic [3:0]         wsum;
	logic [2:0]         wday;
	logic [1:0]         cterm;

	assign era_sgn = 16'(era_q) - 16'(EraBias);
	assign era400  = 24'(era_sgn) * $signed(24'(YearsPerEra));
	assign wsum    = 4'(r7) + 4'(WdayAdj);
	assign wday    = (wsum >= 4'(DaysPerWeek)) ? 3'(wsum - 4'(DaysPerWeek)) : 3'(wsum);
	// doe/36524 - doe/146096 reduces to three compares, since doe <= 146096.
	assign cterm   = 2'(doe >= 18'(DaysPerCent)) + 2'(doe >= 18'(DaysPerCent * 2))
		+ 2'(doe >= 18'(DaysPerCent * 3));

	side_t       side_s9, side_s10, side_s11, side_s12, side_s13, side_s14, side_s15;
	side_t       side_s16;
	logic [1:0]  cterm_s9, cterm_s10;
	logic [17:0] doe_s9, doe_s10, doe_s11, doe_s12, doe_s13;

	// Stages 9..10: four-year cycles, minute and second.
	logic [6:0] q1460;
	logic [5:0] minute;
	logic [5:0] second;

	sec2utc_cdiv #(.W(18), .D(DaysPer4Yr), .QW(7), .RW(11)) u_div_c4 (
		.clk (clk),
		.en  (en_c4),
		.y   (doe),
		.q   (q1460),
		.r   ()
	);

	sec2utc_cdiv #(.W(12), .D(SecPerMin), .QW(6), .RW(6)) u_div_min (
		.clk (clk),
		.en  (en_min),
		.y   (sec_hr),
		.q   (minute),
		.r   (second)
	);

	// Stages 11..13: year of the era.
	logic [17:0] xs_s11;
	logic [8:0]  yoe;

	sec2utc_cdiv #(.W(18), .D(DaysPerYear), .QW(9), .RW(9)) u_div_yr (
		.clk (clk),
		.en  (en_yr),
		.y   (xs_s11),
		.q   (yoe),
		.r   ()
	);

	// Stage 14: day of the March-based year.
	logic [1:0]  c100;
	logic [17:0] doym_full;
	logic [8:0]  doym_s14, doym_s15;
	logic [8:0]  yoe_s14, yoe_s15;

	assign c100 = 2'(yoe >= 9'(YearsPerCent)) + 2'(yoe >= 9'(YearsPerCent * 2))
		+ 2'(yoe >= 9'(YearsPerCent * 3));
	assign doym_full = doe_s13 - (18'(yoe * DaysPerYear) + 18'(yoe >> 2) - 18'(c100));

	// Stage 15: March-based month from the month start table.
	logic [3:0] mp_cnt;
	logic [3:0] mp_s15;

	always_comb begin
		mp_cnt = '0;
		for (int i = 1; i < 12; i++) begin
			if (doym_s14 >= MarchStart[i]) begin
				mp_cnt = 4'(i);
			end
		end
	end

	// Stage 16: January-based month, day of month, year of era and leap flag.
	logic [8:0] yadj;
	logic       leap;
	logic [3:0] mon_s16;
	logic [4:0] dom_s16;
	logic [8:0] yadj_s16;
	logic       leap_s16;

	assign yadj = yoe_s15 + 9'(mp_s15 >= 4'd10);
	// The era starts on a year divisible by 400, so only the year of the era matters.
	assign leap = (yadj[1:0] == 2'b00) && (yadj != 9'(YearsPerCent))
		&& (yadj != 9'(YearsPerCent * 2)) && (yadj != 9'(YearsPerCent * 3));

	// Stage 17: output register.
	result_t res_s17;

	assign m_axis_tdata = res_s17;

	// Pipeline payload registers.
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			x_s1    <= 42'(q128) + 42'(DayDiv * DayBias);
			low7_s1 <= s_axis_tdata[DayShift-1:0];
		end
		if (adv[2]) begin
			xl_s2   <= x_s1[20:0];
			low7_s2 <= low7_s1;
		end
		if (adv[3]) begin
			xl_s3   <= xl_s2;
			low7_s3 <= low7_s2;
		end
		if (adv[4]) begin
			qh_s4   <= qh;
			low7_s4 <= low7_s3;
		end
		if (adv[5]) begin
			qh_s5   <= qh_s4;
			low7_s5 <= low7_s4;
		end
		if (adv[6]) begin
			qa_s6  <= qa;
			zu_s6  <= qa + 32'(ZBias);
			rem_s6 <= {rlo, low7_s5};
		end
		if (adv[9]) begin
			side_s9  <= '{era400: era400, wday: wday, hour: hour, minute: '0, second: '0};
			cterm_s9 <= cterm;
			doe_s9   <= doe;
		end
		if (adv[10]) begin
			side_s10  <= side_s9;
			cterm_s10 <= cterm_s9;
			doe_s10   <= doe_s9;
		end
		if (adv[11]) begin
			side_s11 <= '{era400: side_s10.era400, wday: side_s10.wday,
				hour: side_s10.hour, minute: minute, second: second};
			xs_s11   <= doe_s10 - 18'(q1460) + 18'(cterm_s10);
			doe_s11  <= doe_s10;
		end
		if (adv[12]) begin
			side_s12 <= side_s11;
			doe_s12  <= doe_s11;
		end
		if (adv[13]) begin
			side_s13 <= side_s12;
			doe_s13  <= doe_s12;
		end
		if (adv[14]) begin
			side_s14 <= side_s13;
			doym_s14 <= doym_full[8:0];
			yoe_s14  <= yoe;
		end
		if (adv[15]) begin
			side_s15 <= side_s14;
			doym_s15 <= doym_s14;
			yoe_s15  <= yoe_s14;
			mp_s15   <= mp_cnt;
		end
		if (adv[16]) begin
			side_s16 <= side_s15;
			mon_s16  <= (mp_s15 < 4'd10) ? mp_s15 + 4'd2 : mp_s15 - 4'd10;
			dom_s16  <= 5'(doym_s15 - MarchStart[mp_s15] + 9'd1);
			yadj_s16 <= yadj;
			leap_s16 <= leap;
		end
		if (adv[17]) begin
			res_s17.pad          <= '0;
			res_s17.second       <= side_s16.second;
			res_s17.minute       <= side_s16.minute;
			res_s17.hour         <= side_s16.hour;
			res_s17.weekday      <= side_s16.wday;
			res_s17.day_of_month <= dom_s16;
			res_s17.month_index  <= mon_s16;
			res_s17.year_offset  <= side_s16.era400 + 24'(yadj_s16) - 24'(YearBase);
			res_s17.day_of_year  <= MonthStart[mon_s16] + 9'(dom_s16) - 9'd1
				+ 9'(leap_s16 && (mon_s16 > 4'd1));
		end
	end

endmodule

@@ hdl/sec2utc_chk.sv @@
// Port-level checks of the date converter.
module sec2utc_chk import sec2utc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata
);

	result_t res;

	assign res = result_t'(m_axis_tdata);

	// Each field but year_offset lies in its calendar range; day_of_month is only checked nonzero.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (res.second < 6'd60) && (res.minute < 6'd60)
			&& (res.hour < 5'd24) && (res.day_of_month != 5'd0)
			&& (res.month_index < 4'd12) && (res.weekday < 3'd7)
			&& (res.day_of_year < 9'd366) && (res.pad == 2'b00))
		else $error("result field out of range");

	// A stalled beat holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled output beat changed");

	// With the output register empty no stage can be blocked.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while output register is empty");

	// In January the day of year follows the day of month.
	a_jan: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (res.month_index == 4'd0)
			|-> res.day_of_year == 9'(res.day_of_month) - 9'd1)
		else $error("January day of year mismatch");

	// Reset empties the output.
	a_reset: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("output valid during reset");

endmodule

bind unix_seconds_to_utc_date sec2utc_chk u_sec2utc_chk (.*);
